// ----- src/grd_pkg.sv -----
// grd_pkg: shared types, constants and helper functions of the gamepad report decoder
// used by grd_slot_mem and gamepad_report_decoder; depends on nothing
`default_nettype none

package grd_pkg;

  // default sizes
  localparam int NUM_SLOTS_DEF        = 8;
  localparam int MIN_REPORT_BYTES_DEF = 24;

  // report buffer and byte counter
  localparam int        STORE_DEPTH = 24;
  localparam int        POS_W       = 7;
  localparam logic [6:0] POS_MAX    = 7'd127;
  localparam logic [7:0] HDR_ID     = 8'h01;

  // byte offsets inside a report
  localparam int OFS_HDR0  = 0;
  localparam int OFS_HDR2  = 2;
  localparam int OFS_BTN0  = 8;
  localparam int OFS_BTN1  = 9;
  localparam int OFS_BTN2  = 10;
  localparam int OFS_TRIGL = 11;
  localparam int OFS_TRIGR = 12;
  localparam int OFS_LX    = 16;
  localparam int OFS_LY    = 18;
  localparam int OFS_RX    = 20;
  localparam int OFS_RY    = 22;

  // configuration register indexes and reset values
  localparam int         CFG_IDX_W          = 2;
  localparam int         CFG_DATA_W         = 15;
  localparam logic [1:0] CFG_PAD_HOLD       = 2'd0;
  localparam logic [1:0] CFG_DPAD_DEADZONE  = 2'd1;
  localparam logic [1:0] CFG_TRIG_THRESHOLD = 2'd2;
  localparam logic [9:0]  PAD_HOLD_RST      = 10'd80;
  localparam logic [14:0] DEADZONE_RST      = 15'd6000;
  localparam logic [7:0]  TRIG_THR_RST      = 8'd40;

  // result button bits
  localparam int BTN_B1 = 0;
  localparam int BTN_B2 = 1;
  localparam int BTN_B3 = 2;
  localparam int BTN_B4 = 3;
  localparam int BTN_L1 = 4;
  localparam int BTN_R1 = 5;
  localparam int BTN_L2 = 6;
  localparam int BTN_R2 = 7;
  localparam int BTN_S1 = 8;
  localparam int BTN_S2 = 9;
  localparam int BTN_L3 = 10;
  localparam int BTN_R3 = 11;
  localparam int BTN_A1 = 12;
  localparam int BTN_L4 = 13;
  localparam int BTN_R4 = 14;
  localparam int BTN_DU = 15;
  localparam int BTN_DD = 16;
  localparam int BTN_DL = 17;
  localparam int BTN_DR = 18;
  localparam int BTN_W  = 19;

  localparam logic [7:0] STICK_CENTER = 8'd128;

  // per-slot held state
  typedef struct packed {
    logic [31:0] touch_time;
    logic [7:0]  held_y;
    logic [7:0]  held_x;
  } grd_slot_t;

  localparam grd_slot_t SLOT_RST = '{touch_time: 32'd0, held_y: STICK_CENTER,
                                     held_x: STICK_CENTER};

  // signed sample to 1..255 with 128 center
  function automatic logic [7:0] to_u8(input logic [15:0] v);
    logic [7:0] s;
    s = v[15:8] ^ 8'h80;
    return (s == 8'd0) ? 8'd1 : s;
  endfunction

  // same, inverted
  function automatic logic [7:0] to_u8_inv(input logic [15:0] v);
    logic [7:0] s;
    s = ~to_u8(v);
    return (s == 8'd0) ? 8'd1 : s;
  endfunction

  // pad coordinates: x offset in low half, flipped y in high half
  function automatic logic [31:0] pad_xy(input logic [15:0] x, input logic [15:0] y);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = x ^ 16'h8000;
    hi = 16'h7FFF - y;
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

// ----- src/grd_slot_mem.sv -----
// grd_slot_mem: per-slot state memory, one read and one write port, registered read
// entries not yet written read as the reset state; depends on grd_pkg
`default_nettype none

module grd_slot_mem
  import grd_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output      grd_slot_t     rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire grd_slot_t     wr_data
);

  grd_slot_t              mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   vld_r;
  grd_slot_t              rd_data_r;
  logic                   rd_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // written marks, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : SLOT_RST;

endmodule

`default_nettype wire

// ----- src/gamepad_report_decoder.sv -----
// gamepad_report_decoder: assembles report bytes, validates, decodes one result per valid report
// depends on grd_pkg and grd_slot_mem
// one byte per cycle while in_tready is high; the last accepted byte of a good report loads
// the decode stage, which moves into the result register while that register is not held.
// the per-slot state memory is read at the last byte and written back when the decode
// stage moves into the result register; a held result stalls input only while the decode
// stage is also occupied.
// synchronous reset clears the byte counter, pipeline valids, config registers to defaults
// and the slot memory written marks, so every slot reads as center stick and time zero.
`default_nettype none

module gamepad_report_decoder
  import grd_pkg::*;
#(
  parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
  parameter int MIN_REPORT_BYTES = MIN_REPORT_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [39:0]           in_tdata,   // report_byte[7:0], time_ms[39:8]
  input  wire logic [2:0]            in_tuser,   // slot[2:0]
  input  wire logic                  in_tlast,   // last_byte
  // result stream
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // buttons[18:0], left_x[26:19], left_y[34:27], right_x[42:35], right_y[50:43],
  // left_trigger[58:51], right_trigger[66:59], touch_flags[68:67],
  // left_pad_xy[100:69], right_pad_xy[132:101], zero[135:133]
  output      logic [135:0]          out_tdata,
  output      logic [2:0]            out_tuser,  // slot_out[2:0]
  // configuration
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // configuration registers
  logic [9:0]  pad_hold_r;
  logic [14:0] deadzone_r;
  logic [7:0]  trig_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_hold_r <= PAD_HOLD_RST;
      deadzone_r <= DEADZONE_RST;
      trig_thr_r <= TRIG_THR_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_PAD_HOLD:       pad_hold_r <= cfg_wdata[9:0];
        CFG_DPAD_DEADZONE:  deadzone_r <= cfg_wdata[14:0];
        CFG_TRIG_THRESHOLD: trig_thr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [7:0]  in_byte;
  logic [31:0] in_time;
  assign in_byte = in_tdata[7:0];
  assign in_time = in_tdata[39:8];

  logic in_acc;
  logic out_stall;
  logic b_valid_r;
  logic b_go;

  assign out_stall = out_tvalid && !out_tready;
  assign b_go      = b_valid_r && !out_stall;
  assign in_tready = !(b_valid_r && out_stall);
  assign in_acc    = in_tvalid && in_tready;

  // report buffer and byte counter
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       store_r [STORE_DEPTH];
  logic [7:0]       view    [STORE_DEPTH];

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = (pos_r == POS_W'(i)) ? in_byte : store_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= view[i];
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc) begin
      if (in_tlast) begin
        pos_nxt = '0;
      end else if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // report check on the last byte
  logic [6:0]    slot_ext;
  logic          a_good;
  logic          rd_en;
  logic [AW-1:0] slot_addr;

  assign slot_ext  = {4'b0000, in_tuser};
  assign slot_addr = slot_ext[AW-1:0];
  assign a_good    = (pos_r >= POS_W'(MIN_REPORT_BYTES - 1))
                     && (view[OFS_HDR0] == HDR_ID) && (view[OFS_HDR2] == HDR_ID)
                     && (slot_ext < 7'(NUM_SLOTS));
  assign rd_en     = in_acc && in_tlast && a_good;

  // decode stage context
  logic [2:0]    b_slot_r;
  logic [AW-1:0] b_addr_r;
  logic [31:0]   b_now_r;
  logic [7:0]    b_btn0_r, b_btn1_r, b_btn2_r, b_trigl_r, b_trigr_r;
  logic [15:0]   b_lx_r, b_ly_r, b_rx_r, b_ry_r;
  logic          b_valid_nxt;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (rd_en) begin
      b_valid_nxt = 1'b1;
    end else if (b_go) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_slot_r  <= in_tuser;
      b_addr_r  <= slot_addr;
      b_now_r   <= in_time;
      b_btn0_r  <= view[OFS_BTN0];
      b_btn1_r  <= view[OFS_BTN1];
      b_btn2_r  <= view[OFS_BTN2];
      b_trigl_r <= view[OFS_TRIGL];
      b_trigr_r <= view[OFS_TRIGR];
      b_lx_r    <= {view[OFS_LX + 1], view[OFS_LX]};
      b_ly_r    <= {view[OFS_LY + 1], view[OFS_LY]};
      b_rx_r    <= {view[OFS_RX + 1], view[OFS_RX]};
      b_ry_r    <= {view[OFS_RY + 1], view[OFS_RY]};
    end
  end

  // slot state memory
  grd_slot_t slot_rd;
  grd_slot_t slot_wr;

  grd_slot_mem #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slot_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_addr(slot_addr),
    .rd_data(slot_rd),
    .wr_en  (b_go),
    .wr_addr(b_addr_r),
    .wr_data(slot_wr)
  );

  // decode, modify slot state
  logic            lt, rt, lclick, engaged, dpad;
  logic [31:0]     elapsed;
  logic [16:0]     lx_s, ly_s, dz_pos, dz_neg;
  logic [BTN_W-1:0] btn;
  logic [7:0]      rx_val, ry_val;

  always_comb begin
    lt     = b_btn2_r[3];
    rt     = b_btn2_r[4];
    lclick = b_btn2_r[1];

    slot_wr            = slot_rd;
    slot_wr.touch_time = lt ? b_now_r : slot_rd.touch_time;
    elapsed            = b_now_r - slot_wr.touch_time;
    engaged            = elapsed < {22'd0, pad_hold_r};
    dpad               = lclick && engaged;

    lx_s   = {b_lx_r[15], b_lx_r};
    ly_s   = {b_ly_r[15], b_ly_r};
    dz_pos = {2'b00, deadzone_r};
    dz_neg = 17'd0 - dz_pos;

    btn             = '0;
    btn[BTN_B1]     = b_btn0_r[7];
    btn[BTN_B2]     = b_btn0_r[5];
    btn[BTN_B3]     = b_btn0_r[6];
    btn[BTN_B4]     = b_btn0_r[4];
    btn[BTN_L1]     = b_btn0_r[3];
    btn[BTN_R1]     = b_btn0_r[2];
    btn[BTN_L2]     = (b_trigl_r >= trig_thr_r) || b_btn0_r[1];
    btn[BTN_R2]     = (b_trigr_r >= trig_thr_r) || b_btn0_r[0];
    btn[BTN_S1]     = b_btn1_r[4];
    btn[BTN_S2]     = b_btn1_r[6];
    btn[BTN_A1]     = b_btn1_r[5];
    btn[BTN_L4]     = b_btn1_r[7];
    btn[BTN_R4]     = b_btn2_r[0];
    btn[BTN_R3]     = b_btn2_r[2];
    btn[BTN_L3]     = lclick && !engaged;

    // shared click as d-pad, else sample the stick while the pad is untouched
    if (dpad) begin
      btn[BTN_DU] = $signed(ly_s) > $signed(dz_pos);
      btn[BTN_DD] = $signed(ly_s) < $signed(dz_neg);
      btn[BTN_DL] = $signed(lx_s) < $signed(dz_neg);
      btn[BTN_DR] = $signed(lx_s) > $signed(dz_pos);
    end else if (!lt) begin
      slot_wr.held_x = to_u8(b_lx_r);
      slot_wr.held_y = to_u8_inv(b_ly_r);
    end

    rx_val = rt ? to_u8(b_rx_r)     : STICK_CENTER;
    ry_val = rt ? to_u8_inv(b_ry_r) : STICK_CENTER;
  end

  // result register
  logic         out_valid_r, out_valid_nxt;
  logic [135:0] out_data_r;
  logic [2:0]   out_slot_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_slot_r <= b_slot_r;
      out_data_r <= {3'b000, pad_xy(b_rx_r, b_ry_r), pad_xy(b_lx_r, b_ly_r), rt, lt,
                     b_trigr_r, b_trigl_r, ry_val, rx_val,
                     slot_wr.held_y, slot_wr.held_x, btn};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_slot_r;

  // checks that a slot read never overlaps a pending decode; input flow control does not prevent it
  a_rd_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !b_valid_r)
    else $error("slot read while decode stage busy");

  // read data reaches the decode stage in the next cycle and stays until that stage moves on
  a_rd_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> b_valid_r)
    else $error("decode stage missed slot read");

  // a decoded report always lands in the result register
  a_decode_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_go |=> out_valid_r)
    else $error("decoded result lost");

endmodule

`default_nettype wire
